// ===== src/vdz_pkg.sv =====
`default_nettype none
package vdz_pkg;

  localparam int DEPTH_W     = 32;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;

  localparam logic [DEPTH_W-1:0] NEAR_PLANE_RESET = 32'd205;
  localparam logic [DEPTH_W-1:0] FAR_PLANE_RESET  = 32'd409600000;
  localparam logic               REVERSED_Z_RESET   = 1'b1;
  localparam logic               INFINITE_FAR_RESET = 1'b1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_NEAR_PLANE,
    CFG_FAR_PLANE,
    CFG_REVERSED_Z,
    CFG_INFINITE_FAR
  } cfg_index_t;

  // Control that travels with each request down the divider row.
  typedef struct packed {
    logic valid;
    logic bad;   // rejected input or planes: result 0, invalid 1
    logic sat;   // quotient reaches or passes 1.0
  } vdz_ctl_t;

endpackage
`default_nettype wire

// ===== src/vdz_in_if.sv =====
`default_nettype none
interface vdz_in_if
  import vdz_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [DEPTH_W-1:0] view_depth;

  modport source (output valid, output view_depth, input ready);
  modport sink   (input valid, input view_depth, output ready);
endinterface
`default_nettype wire

// ===== src/vdz_out_if.sv =====
`default_nettype none
interface vdz_out_if #(
  parameter int FRACTION_BITS = 24
);
  logic                   valid;
  logic                   ready;
  logic [FRACTION_BITS:0] device_z;
  logic                   invalid;

  modport source (output valid, output device_z, output invalid, input ready);
  modport sink   (input valid, input device_z, input invalid, output ready);
endinterface
`default_nettype wire

// ===== src/vdz_prep.sv =====
`default_nettype none
module vdz_prep
  import vdz_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire logic               take,
  input  wire logic [DEPTH_W-1:0] view_depth,
  input  wire logic [DEPTH_W-1:0] near_plane,
  input  wire logic [DEPTH_W-1:0] far_plane,
  input  wire logic               reversed_z,
  input  wire logic               infinite_far,
  output vdz_ctl_t                ctl_out,
  output logic      [DEPTH_W-1:0] num_out,
  output logic      [DEPTH_W-1:0] den_out
);

  // Stage 1: reject checks and clamp to the near plane.
  logic               s1_valid;
  logic               s1_bad;
  logic [DEPTH_W-1:0] s1_zc;
  logic               s1_bad_next;
  logic [DEPTH_W-1:0] s1_zc_next;

  always_comb begin
    s1_bad_next = view_depth[DEPTH_W-1] || (view_depth == '0) || (near_plane == '0) ||
                  (!(reversed_z && infinite_far) && (far_plane <= near_plane));
    s1_zc_next  = (view_depth < near_plane) ? near_plane : view_depth;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_bad <= s1_bad_next;
      s1_zc  <= s1_zc_next;
    end
  end

  // Stage 2: pick numerator and denominator for the mode.
  logic               zero;
  logic [DEPTH_W-1:0] num;
  logic [DEPTH_W-1:0] den;
  logic               sat;
  vdz_ctl_t           ctl_next;
  logic [DEPTH_W-1:0] num_next;
  logic [DEPTH_W-1:0] den_next;

  always_comb begin
    zero = reversed_z && !infinite_far && (s1_zc >= far_plane);
    if (reversed_z && infinite_far) begin
      num = near_plane;
      den = s1_zc;
    end else if (reversed_z) begin
      num = far_plane - s1_zc;
      den = far_plane - near_plane;
    end else begin
      num = s1_zc - near_plane;
      den = far_plane - near_plane;
    end
    sat = !zero && (num >= den);
    ctl_next.valid = s1_valid;
    ctl_next.bad   = s1_bad;
    ctl_next.sat   = sat && !s1_bad;
    // Force a zero quotient with a safe divisor where the row's answer is not used.
    if (s1_bad || zero || sat) begin
      num_next = '0;
      den_next = DEPTH_W'(1);
    end else begin
      num_next = num;
      den_next = den;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else if (en) begin
      ctl_out.valid <= ctl_next.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_out.bad <= ctl_next.bad;
      ctl_out.sat <= ctl_next.sat;
      num_out     <= num_next;
      den_out     <= den_next;
    end
  end

endmodule
`default_nettype wire

// ===== src/vdz_cell.sv =====
`default_nettype none
module vdz_cell
  import vdz_pkg::*;
#(
  parameter int FRACTION_BITS = 24
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     en,
  input  wire vdz_ctl_t                 ctl_in,
  input  wire logic [DEPTH_W-1:0]       rem_in,
  input  wire logic [DEPTH_W-1:0]       den_in,
  input  wire logic [FRACTION_BITS-1:0] q_in,
  output vdz_ctl_t                      ctl_out,
  output logic      [DEPTH_W-1:0]       rem_out,
  output logic      [DEPTH_W-1:0]       den_out,
  output logic      [FRACTION_BITS-1:0] q_out
);

  // One restoring step: the remainder stays below the divisor.
  logic [DEPTH_W:0]   shifted;
  logic [DEPTH_W:0]   diff;
  logic               ge;
  logic [DEPTH_W-1:0] rem_next;

  always_comb begin
    shifted  = {rem_in, 1'b0};
    diff     = shifted - {1'b0, den_in};
    ge       = shifted >= {1'b0, den_in};
    rem_next = ge ? diff[DEPTH_W-1:0] : shifted[DEPTH_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else if (en) begin
      ctl_out.valid <= ctl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_out.bad <= ctl_in.bad;
      ctl_out.sat <= ctl_in.sat;
      rem_out     <= rem_next;
      den_out     <= den_in;
      q_out       <= {q_in[FRACTION_BITS-2:0], ge};
    end
  end

endmodule
`default_nettype wire

// ===== src/view_depth_to_device_z_core.sv =====
`default_nettype none
// Maps a view-space depth (signed Q20.12 meters) to a device depth in unsigned fixed
// point with FRACTION_BITS fraction bits, 0 to 1.0. The depth is raised to the near plane,
// then reversed-Z infinite gives near/z, reversed-Z finite gives (far-z)/(far-near) and
// standard-Z gives (z-near)/(far-near), truncated and clamped to 1.0. A nonpositive depth,
// a zero near plane, or far not above near in the finite modes gives 0 with invalid set.
// One request is taken every clock cycle unless the output stage is full; each request
// passes through two setup stages, one divider cell per quotient bit, and the
// output register. A two-entry output stage absorbs a stalled sink, so the input stops
// only once that stage is full. Write the plane and mode registers only while idle.
module view_depth_to_device_z_core
  import vdz_pkg::*;
#(
  parameter int FRACTION_BITS = 24
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  vdz_in_if.sink                      depth,
  vdz_out_if.source                   result
);

  localparam logic [FRACTION_BITS:0] ONE_FIX = {1'b1, {FRACTION_BITS{1'b0}}};

  // Configuration registers.
  logic [DEPTH_W-1:0] near_plane;
  logic [DEPTH_W-1:0] far_plane;
  logic               reversed_z;
  logic               infinite_far;

  always_ff @(posedge clk) begin
    if (rst) begin
      near_plane   <= NEAR_PLANE_RESET;
      far_plane    <= FAR_PLANE_RESET;
      reversed_z   <= REVERSED_Z_RESET;
      infinite_far <= INFINITE_FAR_RESET;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_NEAR_PLANE:   near_plane   <= cfg_data[DEPTH_W-1:0];
        CFG_FAR_PLANE:    far_plane    <= cfg_data[DEPTH_W-1:0];
        CFG_REVERSED_Z:   reversed_z   <= cfg_data[0];
        CFG_INFINITE_FAR: infinite_far <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // The whole row advances together; hold it only while the skid entry is occupied.
  logic en;
  logic skid_valid;

  assign en          = !skid_valid;
  assign depth.ready = en;

  // Row of divider cells; index 0 is the setup output.
  vdz_ctl_t                 ctl_pipe [0:FRACTION_BITS];
  logic [DEPTH_W-1:0]       rem_pipe [0:FRACTION_BITS];
  logic [DEPTH_W-1:0]       den_pipe [0:FRACTION_BITS];
  logic [FRACTION_BITS-1:0] q_pipe   [0:FRACTION_BITS];

  assign q_pipe[0] = '0;

  vdz_prep u_prep (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .take         (depth.valid),
    .view_depth   (depth.view_depth),
    .near_plane   (near_plane),
    .far_plane    (far_plane),
    .reversed_z   (reversed_z),
    .infinite_far (infinite_far),
    .ctl_out      (ctl_pipe[0]),
    .num_out      (rem_pipe[0]),
    .den_out      (den_pipe[0])
  );

  for (genvar i = 0; i < FRACTION_BITS; i++) begin : g_cell
    vdz_cell #(
      .FRACTION_BITS (FRACTION_BITS)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .ctl_in  (ctl_pipe[i]),
      .rem_in  (rem_pipe[i]),
      .den_in  (den_pipe[i]),
      .q_in    (q_pipe[i]),
      .ctl_out (ctl_pipe[i+1]),
      .rem_out (rem_pipe[i+1]),
      .den_out (den_pipe[i+1]),
      .q_out   (q_pipe[i+1])
    );
  end

  // Final value: rejected gives 0, saturated gives 1.0, otherwise the quotient.
  vdz_ctl_t               tail;
  logic [FRACTION_BITS:0] tail_z;

  always_comb begin
    tail = ctl_pipe[FRACTION_BITS];
    if (tail.bad) begin
      tail_z = '0;
    end else if (tail.sat) begin
      tail_z = ONE_FIX;
    end else begin
      tail_z = {1'b0, q_pipe[FRACTION_BITS]};
    end
  end

  // Output register plus one skid entry.
  logic                   out_valid;
  logic [FRACTION_BITS:0] out_z;
  logic                   out_bad;
  logic [FRACTION_BITS:0] skid_z;
  logic                   skid_bad;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (result.ready) begin
        skid_valid <= 1'b0;
      end
    end else if (tail.valid) begin
      if (out_valid && !result.ready) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (result.ready) begin
        out_z   <= skid_z;
        out_bad <= skid_bad;
      end
    end else if (tail.valid) begin
      if (out_valid && !result.ready) begin
        skid_z   <= tail_z;
        skid_bad <= tail.bad;
      end else begin
        out_z   <= tail_z;
        out_bad <= tail.bad;
      end
    end
  end

  assign result.valid    = out_valid;
  assign result.device_z = out_z;
  assign result.invalid  = out_bad;

  // The skid entry fills only behind a waiting output.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry holds a result with no output waiting");

  // A held skid entry keeps its contents until the sink takes the output.
  a_skid_hold: assert property (@(posedge clk) disable iff (rst)
    skid_valid && !result.ready |=> skid_valid && $stable(skid_z) && $stable(skid_bad))
    else $error("skid entry changed while the sink stalled");

  // Rejected results carry zero depth.
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_bad |-> out_z == '0)
    else $error("invalid result with nonzero depth");

  // Results never pass 1.0.
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_z <= ONE_FIX)
    else $error("device depth above 1.0");

  // A frozen row neither gains nor loses a request at its tail.
  a_row_frozen: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(tail.valid) && $stable(q_pipe[FRACTION_BITS]))
    else $error("divider row moved while held");

endmodule
`default_nettype wire
